[rtl/bdq_pkg.sv]
package bdq_pkg;

	localparam int DEPTH       = 16;
	localparam int VALUE_WIDTH = 64;
	localparam int IDX_W       = $clog2(DEPTH);
	localparam int CNT_W       = $clog2(DEPTH + 1);

	// Widths of the channel fields.
	localparam int CMD_W   = 3;
	localparam int DATA_W  = 64;
	localparam int STAT_W  = 2;
	localparam int COUNT_W = 5;

	typedef enum logic [CMD_W-1:0] {
		CMD_PUSH_BACK  = 3'd0,
		CMD_PUSH_FRONT = 3'd1,
		CMD_POP_FRONT  = 3'd2,
		CMD_POP_BACK   = 3'd3,
		CMD_CONTAINS   = 3'd4,
		CMD_REVERSE    = 3'd5
	} cmd_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	typedef struct packed {
		logic [CMD_W-1:0]  cmd;
		logic [DATA_W-1:0] value;
	} req_t;

	typedef struct packed {
		logic [STAT_W-1:0]  status;
		logic               found;
		logic [COUNT_W-1:0] count;
		logic [DATA_W-1:0]  front_value;
		logic [DATA_W-1:0]  back_value;
	} rsp_t;

endpackage

[rtl/bdq_cmd_if.sv]
interface bdq_cmd_if;
	logic                     valid;
	logic                     ready;
	logic [bdq_pkg::CMD_W-1:0]  cmd;
	logic [bdq_pkg::DATA_W-1:0] value;

	modport source (output valid, output cmd, output value, input ready);
	modport sink (input valid, input cmd, input value, output ready);
endinterface

[rtl/bdq_rsp_if.sv]
interface bdq_rsp_if;
	logic                        valid;
	logic                        ready;
	logic [bdq_pkg::STAT_W-1:0]  status;
	logic                        found;
	logic [bdq_pkg::COUNT_W-1:0] count;
	logic [bdq_pkg::DATA_W-1:0]  front_value;
	logic [bdq_pkg::DATA_W-1:0]  back_value;

	modport source (output valid, output status, output found, output count,
		output front_value, output back_value, input ready);
	modport sink (input valid, input status, input found, input count,
		input front_value, input back_value, output ready);
endinterface

[rtl/bdq_store.sv]
module bdq_store (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  bdq_pkg::req_t req,
	output bdq_pkg::rsp_t rsp
);

	// Entries are kept in order from the low end: entry 0 is always the
	// low end and entry occ_q-1 the high end. Reversal only flips rev_q.
	logic [bdq_pkg::VALUE_WIDTH-1:0] ent_q [bdq_pkg::DEPTH];
	logic [bdq_pkg::VALUE_WIDTH-1:0] ent_n [bdq_pkg::DEPTH];
	logic [bdq_pkg::CNT_W-1:0]       occ_q;
	logic [bdq_pkg::CNT_W-1:0]       occ_n;
	logic                            rev_q;
	logic                            rev_n;

	logic                            full;
	logic                            empty;
	logic                            is_push;
	logic                            is_pop;
	logic                            is_contains;
	logic                            is_reverse;
	logic                            push_high;
	logic                            push_low;
	logic                            pop_low;
	logic                            pop_high;
	logic [bdq_pkg::VALUE_WIDTH-1:0] v;
	logic [bdq_pkg::DEPTH-1:0]       match;
	logic [bdq_pkg::IDX_W-1:0]       wr_idx;
	logic [bdq_pkg::IDX_W-1:0]       hi_idx;
	logic [bdq_pkg::VALUE_WIDTH-1:0] lo_val;
	logic [bdq_pkg::VALUE_WIDTH-1:0] hi_val;

	assign full  = (occ_q == bdq_pkg::CNT_W'(bdq_pkg::DEPTH));
	assign empty = (occ_q == '0);
	assign v     = req.value[bdq_pkg::VALUE_WIDTH-1:0];

	always_comb begin
		is_push     = 1'b0;
		is_pop      = 1'b0;
		is_contains = 1'b0;
		is_reverse  = 1'b0;
		case (req.cmd)
			bdq_pkg::CMD_PUSH_BACK, bdq_pkg::CMD_PUSH_FRONT: is_push = 1'b1;
			bdq_pkg::CMD_POP_FRONT, bdq_pkg::CMD_POP_BACK: is_pop = 1'b1;
			bdq_pkg::CMD_CONTAINS: is_contains = 1'b1;
			bdq_pkg::CMD_REVERSE: is_reverse = 1'b1;
			default: ;
		endcase
	end

	// The logical front and back map onto the low or high end by rev_q.
	assign push_high = is_push && !full && ((req.cmd == bdq_pkg::CMD_PUSH_BACK) != rev_q);
	assign push_low  = is_push && !full && ((req.cmd == bdq_pkg::CMD_PUSH_BACK) == rev_q);
	assign pop_low   = is_pop && !empty && ((req.cmd == bdq_pkg::CMD_POP_FRONT) != rev_q);
	assign pop_high  = is_pop && !empty && ((req.cmd == bdq_pkg::CMD_POP_FRONT) == rev_q);

	assign wr_idx = occ_q[bdq_pkg::IDX_W-1:0];

	always_comb begin
		for (int i = 0; i < bdq_pkg::DEPTH; i++) begin
			ent_n[i] = ent_q[i];
			if (push_high && wr_idx == bdq_pkg::IDX_W'(i)) begin
				ent_n[i] = v;
			end else if (push_low) begin
				ent_n[i] = (i == 0) ? v : ent_q[(i == 0) ? 0 : i - 1];
			end else if (pop_low && i < bdq_pkg::DEPTH - 1) begin
				ent_n[i] = ent_q[(i < bdq_pkg::DEPTH - 1) ? i + 1 : i];
			end
		end
	end

	always_comb begin
		occ_n = occ_q;
		if (push_high || push_low) begin
			occ_n = occ_q + 1'b1;
		end else if (pop_low || pop_high) begin
			occ_n = occ_q - 1'b1;
		end
	end

	assign rev_n = rev_q ^ (is_reverse && !empty);

	always_comb begin
		for (int i = 0; i < bdq_pkg::DEPTH; i++) begin
			match[i] = (bdq_pkg::CNT_W'(i) < occ_q) && (ent_q[i] == v);
		end
	end

	assign hi_idx = bdq_pkg::IDX_W'(occ_n - 1'b1);
	assign lo_val = ent_n[0];
	assign hi_val = ent_n[hi_idx];

	always_comb begin
		rsp.status = bdq_pkg::ST_OK;
		if (is_push && full) begin
			rsp.status = bdq_pkg::ST_FULL;
		end else if ((is_pop || is_contains || is_reverse) && empty) begin
			rsp.status = bdq_pkg::ST_EMPTY;
		end
		rsp.found = is_contains && (|match);
		rsp.count = bdq_pkg::COUNT_W'(occ_n);
		if (occ_n == '0) begin
			rsp.front_value = '0;
			rsp.back_value  = '0;
		end else begin
			rsp.front_value = bdq_pkg::DATA_W'(rev_n ? hi_val : lo_val);
			rsp.back_value  = bdq_pkg::DATA_W'(rev_n ? lo_val : hi_val);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ent_q <= ent_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= '0;
			rev_q <= 1'b0;
		end else if (en) begin
			occ_q <= occ_n;
			rev_q <= rev_n;
		end
	end

endmodule

[rtl/bounded_deque_with_search.sv]
// Bounded double-ended queue of 64-bit values with a search command.
// Commands arrive on the request channel (cmd, value) and each one gives
// exactly one transfer on the response channel (status, found, count,
// front_value, back_value), in command order. Both channels transfer on a
// clock edge where valid and ready are high.
// Flow: a command transferred on the request channel is registered in req_s1,
// executed against the store when it advances, and its response is
// registered in rsp_q and offered on the response channel from there.
// Throughput: one command per cycle while the response receiver keeps up.
// All sixteen entries sit in flip-flops, so a search compares every entry
// at once and a push or pop at either end finishes in the execute step.
// When the response receiver stalls, the held response stays valid, the
// registered command waits, and request ready drops once both are occupied;
// nothing is lost or repeated.
// Reset (arst_n low) empties the queue and clears the reversed flag; stored
// entries are not cleared, but none can be read before it is pushed again.
module bounded_deque_with_search (
	input logic     clk,
	input logic     arst_n,
	bdq_cmd_if.sink request,
	bdq_rsp_if.source response
);

	logic          valid_s1;
	bdq_pkg::req_t req_s1;
	logic          advance;
	bdq_pkg::rsp_t rsp_comb;
	logic          out_valid_q;
	bdq_pkg::rsp_t rsp_q;

	assign advance       = valid_s1 && (!out_valid_q || response.ready);
	assign request.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (request.ready) begin
			valid_s1 <= request.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (request.ready && request.valid) begin
			req_s1.cmd   <= request.cmd;
			req_s1.value <= request.value;
		end
	end

	bdq_store u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (advance),
		.req    (req_s1),
		.rsp    (rsp_comb)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (response.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			rsp_q <= rsp_comb;
		end
	end

	assign response.valid       = out_valid_q;
	assign response.status      = rsp_q.status;
	assign response.found       = rsp_q.found;
	assign response.count       = rsp_q.count;
	assign response.front_value = rsp_q.front_value;
	assign response.back_value  = rsp_q.back_value;

endmodule
